/* src/pts_pkg.sv */
// shared constants, payload and control types for the task scheduler
`default_nettype none
package pts_pkg;

    localparam int MAX_TASKS     = 16;
    localparam int PRIORITY_BITS = 3;
    localparam int IDX_W         = $clog2(MAX_TASKS);
    localparam int CNT_W         = $clog2(MAX_TASKS + 1);

    // operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_SLEEP  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    // task modes
    localparam logic [1:0] MODE_RUNNABLE = 2'd0;
    localparam logic [1:0] MODE_RUNNING  = 2'd1;
    localparam logic [1:0] MODE_SLEEPING = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  task_priority;
        logic [31:0] sleep_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  running_task;
        logic        is_started;
        logic [31:0] tick_now;
    } t_out;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                     add;
        logic [IDX_W-1:0]         add_idx;
        logic [PRIORITY_BITS-1:0] add_pri;
        logic                     sleep_set;
        logic [IDX_W-1:0]         sleep_idx;
        logic [31:0]              wake_time;
        logic                     prep;
        logic [31:0]              tick;
        logic                     set_run;
        logic [IDX_W-1:0]         run_idx;
    } t_cmd;

    // search token handed from cell to cell
    typedef struct packed {
        logic                     go;
        logic                     found;
        logic [PRIORITY_BITS-1:0] pri;
        logic [IDX_W-1:0]         idx;
    } t_carry;

endpackage
`default_nettype wire

/* src/priority_task_scheduler_with_sleep_top.sv */
// top level of the priority task scheduler: controller and row of task cells
`default_nettype none
// Fixed-priority task scheduler with sleep. Each transaction on the input
// channel is one operation (start, create, sleep, tick) and gives exactly one
// result transaction carrying status, running task, started flag and tick
// count. Start, create, refused operations and ticks before start go straight
// to the result stage. Sleep and ticks after start reschedule: a prep step
// wakes sleepers whose time is due, then a search token walks the row of
// MAX_TASKS cells at one cell per cycle. One operation is in progress at a
// time; the next is taken while a finished result still waits in the output
// register.
module priority_task_scheduler_with_sleep_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire pts_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output pts_pkg::t_out      o_out
);

    pts_pkg::t_cmd                  w_cmd;
    pts_pkg::t_carry                w_carry [pts_pkg::MAX_TASKS+1];
    logic [pts_pkg::MAX_TASKS-1:0]  w_used;
    logic                           w_inject;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_used      (w_used),
        .i_chain_end (w_carry[pts_pkg::MAX_TASKS]),
        .o_inject    (w_inject),
        .o_cmd       (w_cmd)
    );

    // fresh token enters the first cell
    always_comb begin
        w_carry[0].go    = w_inject;
        w_carry[0].found = 1'b0;
        w_carry[0].pri   = '0;
        w_carry[0].idx   = '0;
    end

    // row of task cells
    for (genvar g = 0; g < pts_pkg::MAX_TASKS; g++) begin : g_cell
        pts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (pts_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_carry (w_carry[g]),
            .o_used  (w_used[g]),
            .o_carry (w_carry[g+1])
        );
    end

endmodule
`default_nettype wire

/* src/pts_cell.sv */
// one task table entry with its stage of the priority search chain
`default_nettype none
module pts_cell (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [pts_pkg::IDX_W-1:0] i_idx,
    input  wire pts_pkg::t_cmd          i_cmd,
    input  wire pts_pkg::t_carry        i_carry,
    output logic                        o_used,
    output pts_pkg::t_carry             o_carry
);

    logic                              r_used;
    logic [pts_pkg::PRIORITY_BITS-1:0] r_pri;
    logic [1:0]                        r_mode;
    logic [31:0]                       r_wake;
    pts_pkg::t_carry                   r_carry;

    logic [1:0]      n_mode;
    pts_pkg::t_carry n_carry;
    logic            w_cand;

    // mode update: create, sleep, wake-up pass, then selection of the winner
    always_comb begin
        n_mode = r_mode;
        if (i_cmd.add && i_cmd.add_idx == i_idx) begin
            n_mode = pts_pkg::MODE_RUNNABLE;
        end
        if (i_cmd.sleep_set && i_cmd.sleep_idx == i_idx) begin
            n_mode = pts_pkg::MODE_SLEEPING;
        end
        if (i_cmd.prep && r_used) begin
            if (r_mode == pts_pkg::MODE_RUNNING) begin
                n_mode = pts_pkg::MODE_RUNNABLE;
            end else if (r_mode == pts_pkg::MODE_SLEEPING && i_cmd.tick >= r_wake) begin
                n_mode = pts_pkg::MODE_RUNNABLE;
            end
        end
        if (i_cmd.set_run && i_cmd.run_idx == i_idx) begin
            n_mode = pts_pkg::MODE_RUNNING;
        end
    end

    // search step: take over the token when strictly better
    always_comb begin
        w_cand = i_carry.go && r_used && r_mode == pts_pkg::MODE_RUNNABLE &&
                 (!i_carry.found || r_pri > i_carry.pri);
        n_carry = i_carry;
        if (w_cand) begin
            n_carry.found = 1'b1;
            n_carry.pri   = r_pri;
            n_carry.idx   = i_idx;
        end
    end

    // control bits and search token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_carry <= '0;
        end else begin
            if (i_cmd.add && i_cmd.add_idx == i_idx) begin
                r_used <= 1'b1;
            end
            r_carry <= n_carry;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        if (i_cmd.add && i_cmd.add_idx == i_idx) begin
            r_pri  <= i_cmd.add_pri;
            r_wake <= 32'd0;
        end
        if (i_cmd.sleep_set && i_cmd.sleep_idx == i_idx) begin
            r_wake <= i_cmd.wake_time;
        end
    end

    assign o_used  = r_used;
    assign o_carry = r_carry;

endmodule
`default_nettype wire

/* src/pts_ctrl.sv */
// operation decoder, scheduler registers and result register
`default_nettype none
module pts_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire pts_pkg::t_in               i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output pts_pkg::t_out                   o_out,
    input  wire logic [pts_pkg::MAX_TASKS-1:0] i_used,
    input  wire pts_pkg::t_carry            i_chain_end,
    output logic                            o_inject,
    output pts_pkg::t_cmd                   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_INJECT = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]                r_state;
    logic [pts_pkg::CNT_W-1:0] r_count;
    logic [pts_pkg::IDX_W-1:0] r_cur;
    logic                      r_started;
    logic [31:0]               r_tick;
    logic [1:0]                r_status;
    logic                      r_out_valid;
    pts_pkg::t_out             r_out;

    logic [2:0] n_state;
    logic [1:0] n_status;
    logic       w_accept;
    logic       w_full;
    logic       w_start_ok;
    logic       w_sleep_ok;
    logic       w_load;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = r_count == pts_pkg::CNT_W'(pts_pkg::MAX_TASKS);
    assign w_start_ok = i_in.operation == pts_pkg::OP_START && !r_started;
    assign w_sleep_ok = i_in.operation == pts_pkg::OP_SLEEP && r_started && i_used[r_cur];
    assign w_load     = r_state == S_FIN && (!r_out_valid || !i_out_stall);

    // broadcast to the cells
    always_comb begin
        o_cmd.add       = w_accept && !w_full &&
                          (w_start_ok || i_in.operation == pts_pkg::OP_CREATE);
        o_cmd.add_idx   = r_count[pts_pkg::IDX_W-1:0];
        o_cmd.add_pri   = (i_in.operation == pts_pkg::OP_START) ?
                          '0 : pts_pkg::PRIORITY_BITS'(i_in.task_priority);
        o_cmd.sleep_set = w_accept && w_sleep_ok;
        o_cmd.sleep_idx = r_cur;
        o_cmd.wake_time = r_tick + i_in.sleep_ticks;
        o_cmd.prep      = r_state == S_PREP;
        o_cmd.tick      = r_tick;
        o_cmd.set_run   = (w_accept && w_start_ok) ||
                          (r_state == S_WAIT && i_chain_end.go && i_chain_end.found);
        o_cmd.run_idx   = (r_state == S_IDLE) ? '0 : i_chain_end.idx;
    end

    // status and next state of the sequencer
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_FIN;
                    n_status = pts_pkg::ST_OK;
                    case (i_in.operation)
                        pts_pkg::OP_START: begin
                            if (r_started) begin
                                n_status = pts_pkg::ST_ILLEGAL;
                            end else if (w_full) begin
                                n_status = pts_pkg::ST_FULL;
                            end
                        end
                        pts_pkg::OP_CREATE: begin
                            if (w_full) begin
                                n_status = pts_pkg::ST_FULL;
                            end
                        end
                        pts_pkg::OP_SLEEP: begin
                            if (w_sleep_ok) begin
                                n_state = S_PREP;
                            end else begin
                                n_status = pts_pkg::ST_ILLEGAL;
                            end
                        end
                        default: begin
                            if (r_started) begin
                                n_state = S_PREP;
                            end
                        end
                    endcase
                end
            end
            S_PREP:   n_state = S_INJECT;
            S_INJECT: n_state = S_WAIT;
            S_WAIT: begin
                if (i_chain_end.go) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // scheduler registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= '0;
            r_started   <= 1'b0;
            r_tick      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.add) begin
                r_count <= r_count + 1'b1;
            end
            if (w_accept && w_start_ok) begin
                r_started <= 1'b1;
                r_cur     <= '0;
            end
            if (w_accept && i_in.operation == pts_pkg::OP_TICK) begin
                r_tick <= r_tick + 32'd1;
            end
            if (r_state == S_WAIT && i_chain_end.go && i_chain_end.found) begin
                r_cur <= i_chain_end.idx;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // status and result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_load) begin
            r_out.status       <= r_status;
            r_out.running_task <= 4'(r_cur);
            r_out.is_started   <= r_started;
            r_out.tick_now     <= r_tick;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_inject    = r_state == S_INJECT;

endmodule
`default_nettype wire

/* src/pts_checker.sv */
// port-level checks for the task scheduler and their binding to the top level
`default_nettype none
module pts_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire pts_pkg::t_out o_out
);

    // an accepted operation keeps the input side busy in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // the block comes out of reset ready for a transaction
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // no status code beyond illegal
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == pts_pkg::ST_OK ||
                         o_out.status == pts_pkg::ST_FULL ||
                         o_out.status == pts_pkg::ST_ILLEGAL))
        else $error("unknown status code");

    // before start the running task is the first entry
    a_idle_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.is_started) |-> o_out.running_task == 4'd0)
        else $error("running task set before start");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind priority_task_scheduler_with_sleep_top pts_checker u_pts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the priority task scheduler with sleep
module testbench;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 5;

    // mirror of the task table and the queue of results still owed by the block
    class sched_scoreboard;
        bit                                slot_used [pts_pkg::MAX_TASKS];
        logic [pts_pkg::PRIORITY_BITS-1:0] slot_pri  [pts_pkg::MAX_TASKS];
        logic [1:0]                        slot_mode [pts_pkg::MAX_TASKS];
        logic [31:0]                       slot_wake [pts_pkg::MAX_TASKS];
        int unsigned                       n_tasks;
        logic [pts_pkg::IDX_W-1:0]         cur_task;
        logic                              started;
        logic [31:0]                       tick_count;
        pts_pkg::t_out                     owed_results [$];
        int unsigned                       mismatches;

        function new();
            for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
                slot_used[i] = 1'b0;
                slot_pri[i]  = '0;
                slot_mode[i] = pts_pkg::MODE_RUNNABLE;
                slot_wake[i] = '0;
            end
            n_tasks    = 0;
            cur_task   = '0;
            started    = 1'b0;
            tick_count = '0;
            mismatches = 0;
        endfunction

        // append a task in creation order, refused once the table is full
        function bit add_slot(logic [pts_pkg::PRIORITY_BITS-1:0] pri);
            if (n_tasks >= pts_pkg::MAX_TASKS)
                return 1'b0;
            slot_used[n_tasks] = 1'b1;
            slot_pri[n_tasks]  = pri;
            slot_mode[n_tasks] = pts_pkg::MODE_RUNNABLE;
            slot_wake[n_tasks] = '0;
            n_tasks++;
            return 1'b1;
        endfunction

        // make the running task runnable, wake due sleepers, then choose the first task of strictly highest priority
        function void pick_next_task();
            bit found;
            int best;
            found = 1'b0;
            best  = 0;
            if (slot_used[cur_task] && slot_mode[cur_task] == pts_pkg::MODE_RUNNING)
                slot_mode[cur_task] = pts_pkg::MODE_RUNNABLE;
            for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
                if (slot_used[i] && slot_mode[i] == pts_pkg::MODE_SLEEPING &&
                    tick_count >= slot_wake[i])
                    slot_mode[i] = pts_pkg::MODE_RUNNABLE;
            end
            for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
                if (slot_used[i] && slot_mode[i] == pts_pkg::MODE_RUNNABLE &&
                    (!found || slot_pri[i] > slot_pri[best])) begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                cur_task        = pts_pkg::IDX_W'(best);
                slot_mode[best] = pts_pkg::MODE_RUNNING;
            end
        endfunction

        // apply one accepted operation and queue the result it must produce
        function void note_input(pts_pkg::t_in item);
            pts_pkg::t_out res;
            res.status = pts_pkg::ST_OK;
            case (item.operation)
                pts_pkg::OP_START: begin
                    if (started) begin
                        res.status = pts_pkg::ST_ILLEGAL;
                    end else begin
                        if (!add_slot('0))
                            res.status = pts_pkg::ST_FULL;
                        cur_task     = '0;
                        slot_mode[0] = pts_pkg::MODE_RUNNING;
                        started      = 1'b1;
                    end
                end
                pts_pkg::OP_CREATE: begin
                    if (!add_slot(item.task_priority))
                        res.status = pts_pkg::ST_FULL;
                end
                pts_pkg::OP_SLEEP: begin
                    if (!started || !slot_used[cur_task]) begin
                        res.status = pts_pkg::ST_ILLEGAL;
                    end else begin
                        slot_wake[cur_task] = tick_count + item.sleep_ticks;
                        slot_mode[cur_task] = pts_pkg::MODE_SLEEPING;
                        pick_next_task();
                    end
                end
                default: begin
                    tick_count = tick_count + 32'd1;
                    if (started)
                        pick_next_task();
                end
            endcase
            res.running_task = cur_task;
            res.is_started   = started;
            res.tick_now     = tick_count;
            owed_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
            $display("mismatch on %s: got %0h, expected %0h", what, got_v, want_v);
            mismatches++;
        endtask

        // compare one result transaction with the oldest owed result
        task check_result(pts_pkg::t_out got);
            pts_pkg::t_out want;
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result, tick_now", got.tick_now, '0);
            end else begin
                want = owed_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.running_task !== want.running_task)
                    report_mismatch("running_task", got.running_task, want.running_task);
                if (got.is_started !== want.is_started)
                    report_mismatch("is_started", got.is_started, want.is_started);
                if (got.tick_now !== want.tick_now)
                    report_mismatch("tick_now", got.tick_now, want.tick_now);
            end
        endtask

        function int unsigned owed_count();
            return owed_results.size();
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    pts_pkg::t_in   in_item   = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    pts_pkg::t_out  out_item;

    sched_scoreboard board;
    int unsigned     gap_pct     = 0;
    int unsigned     stall_pct   = 0;
    int unsigned     stall_hold  = 0;
    int unsigned     idle_cycles = 0;

    priority_task_scheduler_with_sleep_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // gap before the next transaction: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // sleep lengths: mostly short, some far off, some that wrap the counter
    function automatic logic [31:0] pick_sleep_ticks();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 8);
        if (roll < 90)
            return $urandom_range(9, 60);
        if (roll < 95)
            return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endfunction

    function automatic pts_pkg::t_in random_item();
        pts_pkg::t_in item;
        int unsigned  roll;
        roll               = $urandom_range(0, 99);
        item.task_priority = 3'($urandom_range(0, 7));
        item.sleep_ticks   = pick_sleep_ticks();
        if (roll < 45)
            item.operation = pts_pkg::OP_TICK;
        else if (roll < 90)
            item.operation = pts_pkg::OP_SLEEP;
        else if (roll < 95)
            item.operation = pts_pkg::OP_CREATE;
        else
            item.operation = pts_pkg::OP_START;
        return item;
    endfunction

    // offer one transaction and hold it until the block takes it
    task automatic send_item(input pts_pkg::t_in item);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(item);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [2:0] pri,
                           input logic [31:0] ticks);
        pts_pkg::t_in item;
        item.operation     = op;
        item.task_priority = pri;
        item.sleep_ticks   = ticks;
        send_item(item);
    endtask

    // result side: check accepted transactions and stall in bursts
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_item);
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            out_stall  <= ($urandom_range(0, 99) < stall_pct);
            stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int unsigned gap_plan   [PHASES] = '{0, 30, 60, 15, 85};
        int unsigned stall_plan [PHASES] = '{0, 40, 20, 70, 30};
        int unsigned pre_count;

        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operations before start: tick counts, sleep is refused
        gap_pct   = 20;
        stall_pct = 20;
        send_op(pts_pkg::OP_TICK, 3'd0, 32'd0);
        send_op(pts_pkg::OP_SLEEP, 3'd7, 32'hFFFF_FFFF);

        // either fill the table before start or leave room for creates after it
        pre_count = ($urandom_range(0, 1) == 1) ? pts_pkg::MAX_TASKS
                                                : pts_pkg::MAX_TASKS - 2;
        send_op(pts_pkg::OP_CREATE, 3'd7, 32'd0);
        send_op(pts_pkg::OP_CREATE, 3'd0, 32'd0);
        for (int n = 2; n < pre_count; n++)
            send_op(pts_pkg::OP_CREATE, 3'($urandom_range(0, 7)), $urandom);
        if (pre_count == pts_pkg::MAX_TASKS)
            send_op(pts_pkg::OP_CREATE, 3'd5, 32'd0);

        // start, start again, creates after start until the table is full
        send_op(pts_pkg::OP_START, 3'd3, 32'd0);
        send_op(pts_pkg::OP_START, 3'd0, 32'd0);
        send_op(pts_pkg::OP_CREATE, 3'd6, 32'd0);
        send_op(pts_pkg::OP_CREATE, 3'd1, 32'd0);

        // sleep of zero ticks, sleep whose wake time wraps, then ticks
        send_op(pts_pkg::OP_SLEEP, 3'd2, 32'd0);
        send_op(pts_pkg::OP_SLEEP, 3'd4, 32'hFFFF_FFFF);
        send_op(pts_pkg::OP_TICK, 3'd7, 32'hFFFF_FFFF);
        send_op(pts_pkg::OP_TICK, 3'd0, 32'd0);

        // random operations in phases of differing back-pressure
        for (int phase = 0; phase < PHASES; phase++) begin
            gap_pct   = gap_plan[phase];
            stall_pct = stall_plan[phase];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_item(random_item());
        end

        // drain
        in_valid <= 1'b0;
        while (board.owed_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
